// File: src/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg: shared definitions for the stop-and-wait segment receiver
// Constants, controller state and command types, base64 and CRC-32 helpers.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int CHAR_BUFFER_DEPTH_DEF = 64;

  localparam logic [7:0] START_BYTE = 8'h00;
  localparam logic [7:0] END_BYTE   = 8'h04;
  localparam logic [7:0] PAD_CHAR   = 8'h3D;

  localparam int HEADER_BYTES   = 9;
  localparam int OVERHEAD_BYTES = 13;
  localparam int MAX_DELIVER    = 35;

  localparam logic [6:0]  MAX_PAYLOAD_RESET = 7'd64;
  localparam logic [31:0] LAST_ACK_RESET    = 32'hFFFF_FFFE;
  localparam logic [31:0] CRC_POLY          = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT          = 32'hFFFF_FFFF;

  localparam logic [2:0] VERDICT_ACCEPT    = 3'd0;
  localparam logic [2:0] VERDICT_TRUNCATED = 3'd1;
  localparam logic [2:0] VERDICT_DUPLICATE = 3'd2;
  localparam logic [2:0] VERDICT_BAD_CRC   = 3'd3;
  localparam logic [2:0] VERDICT_REJECT    = 3'd4;

  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_STATUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_WAIT,
    ST_READ,
    ST_DEC_RD,
    ST_DEC_PROC,
    ST_FINISH,
    ST_EMIT_RD,
    ST_EMIT_PUT,
    ST_STATUS
  } state_t;

  typedef struct packed {
    logic rx_ready;
    logic clear_count;
    logic store_char;
    logic dec_init;
    logic dec_rd;
    logic dec_proc;
    logic finish;
    logic emit_rd;
    logic load_payload;
    logic load_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_end;
    logic char_full;
    logic dec_done;
    logic emit_done;
    logic out_free;
  } dp_status_t;

  // Bit 6 set means the character is outside the alphabet.
  function automatic logic [6:0] b64_lookup(input logic [7:0] c);
    logic [6:0] r;
    begin
      r = 7'h40;
      if (c >= 8'h41 && c <= 8'h5A) begin
        r = {1'b0, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        r = {1'b0, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        r = {1'b0, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
        r = 7'd62;
      end else if (c == 8'h2F) begin
        r = 7'd63;
      end
      return r;
    end
  endfunction

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    begin
      r = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
    end
  endfunction

endpackage

// File: src/swr_rx_if.sv
// ----------------------------------------------------------------------------
// swr_rx_if: received byte channel
// Valid/ready channel carrying one serial byte per request.
// ----------------------------------------------------------------------------
interface swr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

// File: src/swr_rsp_if.sv
// ----------------------------------------------------------------------------
// swr_rsp_if: result channel
// Valid/ready channel carrying payload bytes and end-of-packet status.
// ----------------------------------------------------------------------------
interface swr_rsp_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  verdict;
  logic        ack_request;
  logic [31:0] ack_sequence;
  logic [5:0]  payload_length;
  logic        last_of_run;

  modport source(output valid, output item_kind, output payload_byte, output verdict,
                 output ack_request, output ack_sequence, output payload_length,
                 output last_of_run, input ready);
  modport sink(input valid, input item_kind, input payload_byte, input verdict,
               input ack_request, input ack_sequence, input payload_length,
               input last_of_run, output ready);
endinterface

// File: src/stop_and_wait_segment_receiver_core.sv
// ----------------------------------------------------------------------------
// stop_and_wait_segment_receiver_core: stop-and-wait segment receiver
// Frames base64 packets, checks CRC-32 and sequence, delivers payload bytes.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// rx        in   one serial byte per request
// rsp       out  payload bytes, then one end-of-packet status
// cfg       in   max_payload register write
//
// A byte that does not end a packet is accepted as soon as it is valid.
// An end byte starts decode, a read and a process step per stored character,
// then a last read and the verdict, then a read and a put per delivered byte
// and the status, plus stalls.
// The single result register lets new bytes be taken while status waits.
// Reset is synchronous and clears the controller, character and emit counters,
// acknowledged number and max_payload; the stores are not cleared.
// ----------------------------------------------------------------------------
module stop_and_wait_segment_receiver_core
  import swr_pkg::*;
#(
  parameter int CHAR_BUFFER_DEPTH = CHAR_BUFFER_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  swr_rx_if.sink     rx,
  swr_rsp_if.source  rsp,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  assign rx.ready = cmd.rx_ready;

  swr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  swr_dp #(
    .CHAR_BUFFER_DEPTH(CHAR_BUFFER_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .rx_byte        (rx.rx_byte),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .item_kind      (rsp.item_kind),
    .payload_byte   (rsp.payload_byte),
    .verdict        (rsp.verdict),
    .ack_request    (rsp.ack_request),
    .ack_sequence   (rsp.ack_sequence),
    .payload_length (rsp.payload_length),
    .last_of_run    (rsp.last_of_run)
  );

endmodule

// File: src/swr_ctrl.sv
// ----------------------------------------------------------------------------
// swr_ctrl: receiver controller
// Sequences framing, decode, verdict and result delivery.
// ----------------------------------------------------------------------------
module swr_ctrl
  import swr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_WAIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_WAIT: begin
        if (rx_valid && sts.is_start) state_next = ST_READ;
      end
      ST_READ: begin
        if (rx_valid) begin
          if (sts.is_end) state_next = ST_DEC_RD;
          else if (sts.char_full) state_next = ST_WAIT;
        end
      end
      ST_DEC_RD: begin
        state_next = sts.dec_done ? ST_FINISH : ST_DEC_PROC;
      end
      ST_DEC_PROC: state_next = ST_DEC_RD;
      ST_FINISH:   state_next = ST_EMIT_RD;
      ST_EMIT_RD: begin
        state_next = sts.emit_done ? ST_STATUS : ST_EMIT_PUT;
      end
      ST_EMIT_PUT: begin
        if (sts.out_free) state_next = ST_EMIT_RD;
      end
      ST_STATUS: begin
        if (sts.out_free) state_next = ST_WAIT;
      end
      default: state_next = ST_WAIT;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_WAIT: begin
        cmd.rx_ready    = 1'b1;
        cmd.clear_count = rx_valid && sts.is_start;
      end
      ST_READ: begin
        cmd.rx_ready    = 1'b1;
        cmd.dec_init    = rx_valid && sts.is_end;
        cmd.store_char  = rx_valid && !sts.is_end && !sts.char_full;
        cmd.clear_count = rx_valid && !sts.is_end && sts.char_full;
      end
      ST_DEC_RD:   cmd.dec_rd = !sts.dec_done;
      ST_DEC_PROC: cmd.dec_proc = 1'b1;
      ST_FINISH:   cmd.finish = 1'b1;
      ST_EMIT_RD:  cmd.emit_rd = !sts.emit_done;
      ST_EMIT_PUT: cmd.load_payload = sts.out_free;
      ST_STATUS: begin
        cmd.load_status = sts.out_free;
        cmd.clear_count = sts.out_free;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// File: src/swr_dp.sv
// ----------------------------------------------------------------------------
// swr_dp: receiver datapath
// Character store, base64 decoder, CRC-32, segment store and result register.
// ----------------------------------------------------------------------------
module swr_dp
  import swr_pkg::*;
#(
  parameter int CHAR_BUFFER_DEPTH = CHAR_BUFFER_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_status_t  sts,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic        item_kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  verdict,
  output logic        ack_request,
  output logic [31:0] ack_sequence,
  output logic [5:0]  payload_length,
  output logic        last_of_run
);

  localparam int DecMax = (CHAR_BUFFER_DEPTH * 3) / 4 + 4;
  localparam int CW     = $clog2(CHAR_BUFFER_DEPTH + 1);
  localparam int CAW    = $clog2(CHAR_BUFFER_DEPTH);
  localparam int NW     = $clog2(DecMax + 1);
  localparam int SAW    = $clog2(DecMax);

  logic [7:0]  char_store [CHAR_BUFFER_DEPTH];
  logic [7:0]  seg_store [DecMax];
  logic [CW-1:0] char_count, dec_idx;
  logic [7:0]  char_rd, seg_rd;
  logic [NW-1:0] seg_n;
  logic [13:0] acc;
  logic [3:0]  nbits;
  logic [1:0]  pads;
  logic        bad;
  logic [31:0] crc, window, seq, last_acked;
  logic        flag_ack;
  logic [6:0]  max_payload;
  logic [5:0]  deliver, emit_idx;
  logic [2:0]  st_verdict;
  logic        st_ackr;
  logic [31:0] st_ackseq;
  logic [5:0]  st_plen;

  logic [6:0]  b64v;
  logic [13:0] acc_cat;
  logic [3:0]  nb, nb_rem;
  logic [13:0] acc_masked;
  logic [7:0]  dec_byte;
  logic        produce;
  logic [8:0]  plen9, del9;
  logic [2:0]  fin_verdict;
  logic        fin_new;
  logic        fin_ackr;
  logic [5:0]  fin_plen;

  assign sts.is_start  = rx_byte == START_BYTE;
  assign sts.is_end    = rx_byte == END_BYTE;
  assign sts.char_full = char_count == CW'(CHAR_BUFFER_DEPTH);
  assign sts.dec_done  = dec_idx == char_count;
  assign sts.emit_done = emit_idx == deliver;
  assign sts.out_free  = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= MAX_PAYLOAD_RESET;
    end else if (cfg_we) begin
      max_payload <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count <= '0;
    end else if (cmd.clear_count) begin
      char_count <= '0;
    end else if (cmd.store_char) begin
      char_count <= char_count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_char) begin
      char_store[char_count[CAW-1:0]] <= rx_byte;
    end
    if (cmd.dec_rd) begin
      char_rd <= char_store[dec_idx[CAW-1:0]];
    end
  end

  always_comb begin
    b64v       = b64_lookup(char_rd);
    acc_cat    = {acc[7:0], b64v[5:0]};
    nb         = nbits + 4'd6;
    nb_rem     = nb - 4'd8;
    dec_byte   = 8'(acc_cat >> nb_rem);
    acc_masked = acc_cat & ((14'd1 << nb_rem) - 14'd1);
    produce    = cmd.dec_proc && char_rd != PAD_CHAR && pads == 2'd0 && !b64v[6]
                 && nb >= 4'd8;
  end

  always_ff @(posedge clk) begin
    if (cmd.dec_init) begin
      dec_idx <= '0;
      seg_n   <= '0;
      acc     <= '0;
      nbits   <= '0;
      pads    <= '0;
      bad     <= 1'b0;
      crc     <= CRC_INIT;
    end else begin
      if (cmd.dec_rd) dec_idx <= dec_idx + CW'(1);
      if (cmd.dec_proc) begin
        if (char_rd == PAD_CHAR) begin
          if (pads != 2'd3) pads <= pads + 2'd1;
        end else if (pads != 2'd0 || b64v[6]) begin
          bad <= 1'b1;
        end else if (nb >= 4'd8) begin
          acc   <= acc_masked;
          nbits <= nb_rem;
        end else begin
          acc   <= acc_cat;
          nbits <= nb;
        end
      end
      if (produce) begin
        seg_n  <= seg_n + NW'(1);
        window <= {dec_byte, window[31:8]};
        if (seg_n >= NW'(4)) crc <= crc32_byte(crc, window[7:0]);
        if (seg_n == NW'(0)) flag_ack <= dec_byte[0];
        if (seg_n == NW'(1)) seq[7:0] <= dec_byte;
        if (seg_n == NW'(2)) seq[15:8] <= dec_byte;
        if (seg_n == NW'(3)) seq[23:16] <= dec_byte;
        if (seg_n == NW'(4)) seq[31:24] <= dec_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      seg_store[seg_n[SAW-1:0]] <= dec_byte;
    end
    if (cmd.emit_rd) begin
      seg_rd <= seg_store[SAW'(HEADER_BYTES) + SAW'(emit_idx)];
    end
  end

  always_comb begin
    plen9 = 9'(seg_n) - 9'(OVERHEAD_BYTES);
    del9  = plen9;
    if (del9 > 9'(max_payload)) del9 = 9'(max_payload);
    if (del9 > 9'(MAX_DELIVER)) del9 = 9'(MAX_DELIVER);
  end

  always_comb begin
    fin_plen    = (plen9 > 9'd63) ? 6'd63 : plen9[5:0];
    fin_new     = 1'b0;
    fin_ackr    = 1'b0;
    fin_verdict = VERDICT_REJECT;
    if (bad || pads == 2'd3 || seg_n < NW'(OVERHEAD_BYTES)) begin
      fin_verdict = VERDICT_REJECT;
    end else if (~crc != window) begin
      fin_verdict = VERDICT_BAD_CRC;
    end else if (!flag_ack && seq == last_acked + 32'd1) begin
      fin_new     = 1'b1;
      fin_ackr    = 1'b1;
      fin_verdict = (del9 < plen9) ? VERDICT_TRUNCATED : VERDICT_ACCEPT;
    end else if (!flag_ack && seq == last_acked) begin
      fin_ackr    = 1'b1;
      fin_verdict = VERDICT_DUPLICATE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_acked <= LAST_ACK_RESET;
      deliver    <= '0;
      emit_idx   <= '0;
    end else if (cmd.finish) begin
      emit_idx   <= '0;
      deliver    <= fin_new ? del9[5:0] : 6'd0;
      st_verdict <= fin_verdict;
      st_ackr    <= fin_ackr;
      st_ackseq  <= fin_ackr ? seq : 32'd0;
      st_plen    <= fin_ackr ? fin_plen : 6'd0;
      if (fin_new) last_acked <= seq;
    end else if (cmd.emit_rd) begin
      emit_idx <= emit_idx + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_payload || cmd.load_status) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_payload) begin
      item_kind      <= ITEM_PAYLOAD;
      payload_byte   <= seg_rd;
      verdict        <= VERDICT_ACCEPT;
      ack_request    <= 1'b0;
      ack_sequence   <= '0;
      payload_length <= '0;
      last_of_run    <= 1'b0;
    end else if (cmd.load_status) begin
      item_kind      <= ITEM_STATUS;
      payload_byte   <= '0;
      verdict        <= st_verdict;
      ack_request    <= st_ackr;
      ack_sequence   <= st_ackseq;
      payload_length <= st_plen;
      last_of_run    <= 1'b1;
    end
  end

endmodule
